// File: rtl/core/pbpt_pkg.sv
// Shared types and constants for the program bank page table.
// Used by pbpt_front, pbpt_queue, pbpt_back and prg_bank_page_table.
`timescale 1ns / 1ps

package pbpt_pkg;

  localparam int NUM_SLOTS  = 32;
  localparam int SLOT_W     = 5;
  localparam int PAGE_W     = 11;
  localparam int OFFSET_W   = 11;
  localparam int CODE_W     = 4;
  localparam int K_W        = 3;
  localparam int MAX_K      = 4;
  localparam int SPAN_W     = 4;
  localparam int CHIP_W     = 2;
  localparam int CADDR_W    = 22;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W  = 3;

  // Input item selector.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_MAP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // What a slot currently holds.
  typedef enum logic [1:0] {
    KIND_MAPPED   = 2'd0,
    KIND_UNMAPPED = 2'd1,
    KIND_CLEARED  = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP0_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP1_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP2_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP3_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_FLAGS  = 3'd4;

  // One slot table entry.
  typedef struct packed {
    kind_t              kind;
    logic               ram;
    logic [CHIP_W-1:0]  chip;
    logic [PAGE_W-1:0]  page;
  } slot_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_t                  op;
    logic [SLOT_W-1:0]    slot;
    logic [OFFSET_W-1:0]  offset;
    logic [7:0]           wdata;
    logic [7:0]           open_bus;
    logic [K_W-1:0]       k;
    logic [PAGE_W-1:0]    page_base;
    logic [PAGE_W-1:0]    page_mask;
    logic                 present;
    logic                 ram;
    logic [CHIP_W-1:0]    chip;
  } cmd_t;

endpackage

// File: rtl/core/pbpt_front.sv
// Front end of the page table: holds the chip configuration, accepts items
// and turns them into classified commands. Depends on pbpt_pkg.
`timescale 1ns / 1ps

module pbpt_front
  import pbpt_pkg::*;
#(
  parameter int NUM_CHIPS = 4,
  parameter int PAGE_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CODE_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  op_t                   in_op,
  input  logic [15:0]           in_address,
  input  logic [15:0]           in_value,
  input  logic [CHIP_W-1:0]     in_chip,
  input  logic [K_W-1:0]        in_bank_size,
  input  logic [7:0]            in_open_bus,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  logic [CODE_W-1:0] size_code_r [4];
  logic [3:0]        ram_flags_r;

  logic              chip_ok;
  logic [CODE_W-1:0] code_raw;
  logic [CODE_W-1:0] code_clamped;
  logic [K_W-1:0]    k_c;
  logic [PAGE_W-1:0] shifted;

  // Configuration registers; the user must write them only while the block is idle; it does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        size_code_r[i] <= '0;
      end
      ram_flags_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHIP0_SIZE: size_code_r[0] <= cfg_wdata;
        CFG_CHIP1_SIZE: size_code_r[1] <= cfg_wdata;
        CFG_CHIP2_SIZE: size_code_r[2] <= cfg_wdata;
        CFG_CHIP3_SIZE: size_code_r[3] <= cfg_wdata;
        CFG_RAM_FLAGS:  ram_flags_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: take an item whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Chip lookup; a chip number beyond the fitted chips counts as absent.
  assign chip_ok  = {1'b0, in_chip} < 3'(NUM_CHIPS);
  assign code_raw = chip_ok ? size_code_r[in_chip] : '0;

  always_comb begin
    if (code_raw > CODE_W'(PAGE_BITS + 1)) begin
      code_clamped = CODE_W'(PAGE_BITS + 1);
    end else begin
      code_clamped = code_raw;
    end
  end

  // Bank size above 32 KB is treated as 32 KB.
  assign k_c     = (in_bank_size > K_W'(MAX_K)) ? K_W'(MAX_K) : in_bank_size;
  assign shifted = PAGE_W'(in_value << k_c);

  // Build the classified command.
  always_comb begin
    q_cmd           = '0;
    q_cmd.op        = in_op;
    q_cmd.slot      = in_address[15 -: SLOT_W];
    q_cmd.offset    = in_address[OFFSET_W-1:0];
    q_cmd.wdata     = in_value[7:0];
    q_cmd.open_bus  = in_open_bus;
    q_cmd.k         = k_c;
    q_cmd.page_base = shifted;
    q_cmd.present   = code_raw != '0;
    q_cmd.ram       = chip_ok && ram_flags_r[in_chip];
    q_cmd.chip      = in_chip;
    for (int j = 0; j < PAGE_W; j++) begin
      q_cmd.page_mask[j] = (j < PAGE_BITS) && (CODE_W'(j + 1) < code_clamped);
    end
  end

endmodule

// File: rtl/core/pbpt_queue.sv
// Two-entry command queue between the front and the back of the page table.
// Depends on pbpt_pkg.
`timescale 1ns / 1ps

module pbpt_queue
  import pbpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  cmd_t  push_cmd,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output cmd_t  head_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t                 mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [PTR_W:0]       count_r;
  logic [PTR_W-1:0]     wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_nxt;
  logic [PTR_W:0]       count_nxt;

  assign full      = count_r == (PTR_W + 1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head_cmd  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; the count guards it.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/pbpt_back.sv
// Back end of the page table: owns the slot table, applies map and clear
// commands and resolves accesses into registered results. Depends on pbpt_pkg.
`timescale 1ns / 1ps

module pbpt_back
  import pbpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kind_t                out_kind,
  output logic [CHIP_W-1:0]    out_chip,
  output logic [CADDR_W-1:0]   out_caddr,
  output logic                 out_we,
  output logic [7:0]           out_wdata,
  output logic [7:0]           out_rdata
);

  slot_t               table_r [NUM_SLOTS];
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [CHIP_W-1:0]   out_chip_r;
  logic [CADDR_W-1:0]  out_caddr_r;
  logic                out_we_r;
  logic [7:0]          out_wdata_r;
  logic [7:0]          out_rdata_r;

  logic                is_access;
  logic                load_out;
  slot_t               entry;
  kind_t               res_kind;
  logic [CHIP_W-1:0]   res_chip;
  logic [CADDR_W-1:0]  res_caddr;
  logic                res_we;
  logic [7:0]          res_wdata;
  logic [7:0]          res_rdata;

  // A command leaves the queue once the output register can take its result.
  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign is_access = (q_cmd.op == OP_READ) || (q_cmd.op == OP_WRITE);
  assign load_out  = q_pop && is_access;

  // Slot table: every covered slot of a map is written in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        table_r[i] <= '{kind: KIND_CLEARED, ram: 1'b0, chip: '0, page: '0};
      end
    end else if (q_pop && q_cmd.op == OP_CLEAR) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        table_r[i] <= '{kind: KIND_CLEARED, ram: 1'b0, chip: '0, page: '0};
      end
    end else if (q_pop && q_cmd.op == OP_MAP) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        logic [SLOT_W-1:0] x;
        logic [PAGE_W-1:0] page;
        x    = SLOT_W'(i) - q_cmd.slot;
        page = (q_cmd.page_base + PAGE_W'(x)) & q_cmd.page_mask;
        if ((x >> q_cmd.k) == '0) begin
          if (q_cmd.present) begin
            table_r[i] <= '{kind: KIND_MAPPED, ram: q_cmd.ram,
                            chip: q_cmd.chip, page: page};
          end else begin
            table_r[i] <= '{kind: KIND_UNMAPPED, ram: 1'b0, chip: '0, page: '0};
          end
        end
      end
    end
  end

  // Resolve an access against the addressed slot.
  assign entry = table_r[q_cmd.slot];

  always_comb begin
    res_kind  = entry.kind;
    res_chip  = '0;
    res_caddr = '0;
    res_we    = 1'b0;
    res_wdata = '0;
    res_rdata = '0;
    if (entry.kind == KIND_MAPPED) begin
      res_chip  = entry.chip;
      res_caddr = {entry.page, q_cmd.offset};
    end
    if (q_cmd.op == OP_WRITE) begin
      if (entry.kind == KIND_MAPPED && entry.ram) begin
        res_we    = 1'b1;
        res_wdata = q_cmd.wdata;
      end
    end else if (entry.kind == KIND_UNMAPPED) begin
      res_rdata = q_cmd.open_bus;
    end
  end

  // Output register; it parts the queue from the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r  <= res_kind;
      out_chip_r  <= res_chip;
      out_caddr_r <= res_caddr;
      out_we_r    <= res_we;
      out_wdata_r <= res_wdata;
      out_rdata_r <= res_rdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_chip  = out_chip_r;
  assign out_caddr = out_caddr_r;
  assign out_we    = out_we_r;
  assign out_wdata = out_wdata_r;
  assign out_rdata = out_rdata_r;

endmodule

// File: rtl/core/prg_bank_page_table.sv
// Top level of the program bank page table: front, command queue and back.
// Depends on pbpt_pkg, pbpt_front, pbpt_queue and pbpt_back.
`timescale 1ns / 1ps
//
// The block maps a 64 KB CPU space in 32 slots of 2 KB onto pages of up to
// four memory chips. Items enter on the in_ stream: in_tuser selects read,
// write, map bank or clear all. Reads and writes give one item on the out_
// stream (kind in out_tuser); map and clear give none. The cfg_ port writes
// the chip size codes and RAM flags, one register per cycle; the user must
// write them only while idle, which the block does not enforce. Throughput is
// one item per cycle while the receiver takes results; the slot table is in
// flip-flops and a map rewrites all covered slots at once. An accepted item
// enters the two-entry queue; once it is at the head and the output register
// is free, its result is registered and out_tvalid rises. When the receiver
// stalls, the result holds in the output register, the queue fills and
// in_tready drops once two commands are waiting. Reset (rst_n low, synchronous)
// clears the queue and the output register, sets every slot to cleared and
// zeroes all configuration registers.

module prg_bank_page_table
  import pbpt_pkg::*;
#(
  parameter int NUM_CHIPS = 4,
  parameter int PAGE_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CODE_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // address[15:0], value[31:16], chip[33:32], bank_size[36:34],
  // open_bus_value[44:37], zero fill[47:45]
  input  logic [47:0]           in_tdata,
  // func[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // target_chip[1:0], chip_address[23:2], write_enable[24],
  // write_data[32:25], read_data[40:33], zero fill[47:41]
  output logic [47:0]           out_tdata,
  // access_kind[1:0]
  output logic [1:0]            out_tuser
);

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_not_empty;
  cmd_t                 push_cmd;
  cmd_t                 head_cmd;
  kind_t                out_kind;
  logic [CHIP_W-1:0]    out_chip;
  logic [CADDR_W-1:0]   out_caddr;
  logic                 out_we;
  logic [7:0]           out_wdata;
  logic [7:0]           out_rdata;

  // Accept and classify items.
  pbpt_front #(
    .NUM_CHIPS (NUM_CHIPS),
    .PAGE_BITS (PAGE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (op_t'(in_tuser)),
    .in_address   (in_tdata[15:0]),
    .in_value     (in_tdata[31:16]),
    .in_chip      (in_tdata[33:32]),
    .in_bank_size (in_tdata[36:34]),
    .in_open_bus  (in_tdata[44:37]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // Command queue between the two halves.
  pbpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // Slot table and result register.
  pbpt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_kind),
    .out_chip    (out_chip),
    .out_caddr   (out_caddr),
    .out_we      (out_we),
    .out_wdata   (out_wdata),
    .out_rdata   (out_rdata)
  );

  // Pack the result item.
  assign out_tdata = {7'd0, out_rdata, out_wdata, out_we, out_caddr, out_chip};
  assign out_tuser = out_kind;

`ifndef SYNTHESIS
  // A write is only enabled on a mapped slot.
  a_we_mapped : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[24]) |-> (out_tuser == KIND_MAPPED))
    else $error("write enabled on a slot that is not mapped");

  // Read data is nonzero only for open bus results.
  a_rdata_open_bus : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[40:33] != 8'd0)) |-> (out_tuser == KIND_UNMAPPED))
    else $error("read data on a result that is not open bus");

  // Chip address is zero unless the slot is mapped.
  a_caddr_mapped : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != KIND_MAPPED)) |-> (out_tdata[23:0] == 24'd0))
    else $error("chip address on an unmapped or cleared slot");

  // The queue never pops while empty nor pushes while full.
  a_queue_bounds : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && !q_not_empty) && !(q_push && q_full))
    else $error("command queue overflow or underflow");
`endif

endmodule
